### hdl/crtlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Control rod table package
// Shared types, command and status codes, and default sizes.
// ----------------------------------------------------------------------------
package crtlc_pkg;

  localparam int unsigned RodCountDef    = 128;
  localparam int unsigned GroupCountDef  = 16;
  localparam int unsigned MaxSegmentsDef = 4;
  localparam int unsigned TypeCountDef   = 4;

  localparam int unsigned PosW  = 24;
  localparam int unsigned FracW = 17;
  localparam logic [FracW-1:0] OneQ16 = 17'h10000;

  typedef enum logic [2:0] {
    CMD_LOAD_ROD  = 3'd0,
    CMD_LOAD_SEG  = 3'd1,
    CMD_MOVE      = 3'd2,
    CMD_SCRAM     = 3'd3,
    CMD_MEAN      = 3'd4,
    CMD_COVER     = 3'd5
  } cmd_e;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SWEEP, S_SEG_RD, S_SEG_ACC, S_DIV_START, S_DIV, S_EMIT, S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  rod_index;
    logic [4:0]  group;
    logic [23:0] position;
    logic [2:0]  segment_count;
    logic [1:0]  segment_index;
    logic [23:0] segment_length;
    logic [2:0]  segment_type;
    logic [23:0] z_center;
    logic [23:0] layer_height;
  } in_t;

  typedef struct packed {
    logic [16:0] fraction;
    logic [2:0]  type_index;
    logic [23:0] group_mean;
    logic [1:0]  status;
    logic        last;
  } out_t;

endpackage
`default_nettype wire

### hdl/crtlc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one transaction payload of a parameterized type.
// ----------------------------------------------------------------------------
interface crtlc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/crtlc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crtlc_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial - {1'b0, den_q};
          quo_d = {quo_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          quo_d = {quo_q[NumW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o = quo_q;
endmodule
`default_nettype wire

### hdl/control_rod_table_and_layer_cover.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Control rod table and layer cover
// Rod table with group moves, scram, group mean and per-type layer cover.
//
// Channel  Dir  Payload
// cmd      in   command and operands (in_t)
// res      out  fraction, type_index, group_mean, status, last (out_t)
//
// Move, scram and mean sweep the rod table one rod per cycle; mean then adds one
// serial division. Layer cover reads the segments of one rod in turn, reading and
// then accumulating each, then runs TYPE_COUNT serial divisions on one divider.
// Reset clears the rod tables through valid bits; segment storage is not reset.
// A result waits in the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module control_rod_table_and_layer_cover #(
  parameter int unsigned ROD_COUNT    = crtlc_pkg::RodCountDef,
  parameter int unsigned GROUP_COUNT  = crtlc_pkg::GroupCountDef,
  parameter int unsigned MAX_SEGMENTS = crtlc_pkg::MaxSegmentsDef,
  parameter int unsigned TYPE_COUNT   = crtlc_pkg::TypeCountDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  crtlc_stream_if.sink   cmd,
  crtlc_stream_if.source res
);
  import crtlc_pkg::*;

  localparam int unsigned RodW  = (ROD_COUNT > 1) ? $clog2(ROD_COUNT) : 1;
  localparam int unsigned SegW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SegCW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned TypW  = $clog2(TYPE_COUNT + 1);
  localparam int unsigned EntW  = RodW + SegW;
  localparam int unsigned CntW  = $clog2(ROD_COUNT + 1);
  localparam int unsigned SumW  = PosW + CntW;
  localparam int unsigned LenW  = 32;
  localparam int unsigned NumW  = 48;
  localparam int unsigned DenW  = 32;

  logic [4:0]       grp_mem [ROD_COUNT];
  logic [PosW-1:0]  bot_mem [ROD_COUNT];
  logic [SegCW-1:0] nseg_mem[ROD_COUNT];
  logic [ROD_COUNT-1:0] rvalid_q;
  logic [PosW-1:0]  len_mem [ROD_COUNT*MAX_SEGMENTS];
  logic [TypW-1:0]  typ_mem [ROD_COUNT*MAX_SEGMENTS];

  state_e state_q, state_d;
  in_t    in_q;
  out_t   out_q, out_d;
  out_t   work_q, work_d;
  logic   ovalid_q, ovalid_d;

  logic [RodW-1:0]  idx_q, idx_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SegCW-1:0] seg_q, seg_d;
  logic [SegCW-1:0] nseg_q, nseg_d;
  logic [26:0]      pt2_q, pt2_d;
  logic [LenW-1:0]  cov_q[TYPE_COUNT+1], cov_d[TYPE_COUNT+1];
  logic [FracW-1:0] frac_q[TYPE_COUNT+1], frac_d[TYPE_COUNT+1];
  logic [TypW-1:0]  t_q, t_d;
  logic             mean_q, mean_d;

  logic [4:0]       grp_rd_q;
  logic [PosW-1:0]  bot_rd_q;
  logic [SegCW-1:0] nseg_rd_q;
  logic [4:0]       rd_grp;
  logic [PosW-1:0]  rd_bot;
  logic [SegCW-1:0] rd_nseg;
  logic             rd_valid;
  logic [PosW-1:0]  sl_q;
  logic [TypW-1:0]  st_q;

  logic             div_start, div_done;
  logic [NumW-1:0]  div_num, div_quo;
  logic [DenW-1:0]  div_den;

  logic             bad, wr_rod, wr_seg, wr_bot;
  logic [RodW-1:0]  wr_rod_idx;
  logic [EntW-1:0]  wr_ent, rd_ent;
  logic [PosW-1:0]  wr_bot_val;
  logic [27:0]      bot2, top2, lo, hi;
  logic [FracW-1:0] fcl;
  logic [2*FracW:0] fsum_w;

  assign cmd.ready = (state_q == S_IDLE);
  assign res.valid = ovalid_q;
  assign res.data  = out_q;

  assign rd_valid = rvalid_q[idx_q];
  assign rd_grp   = rd_valid ? grp_rd_q : 5'd0;
  assign rd_bot   = rd_valid ? bot_rd_q : '0;
  assign rd_nseg  = rd_valid ? nseg_rd_q : '0;
  assign rd_ent   = {idx_q, seg_q[SegW-1:0]};

  assign bot2 = ({3'b0, in_q.z_center, 1'b0} >= {4'b0, in_q.layer_height})
                ? ({3'b0, in_q.z_center, 1'b0} - {4'b0, in_q.layer_height}) : '0;
  assign top2 = {3'b0, in_q.z_center, 1'b0} + {4'b0, in_q.layer_height};

  always_comb begin
    bad = 1'b0;
    unique case (in_q.command)
      CMD_LOAD_ROD: bad = (32'(in_q.rod_index) >= ROD_COUNT)
                          || (32'(in_q.group) > GROUP_COUNT)
                          || (32'(in_q.segment_count) > MAX_SEGMENTS);
      CMD_LOAD_SEG: bad = (32'(in_q.rod_index) >= ROD_COUNT)
                          || (32'(in_q.segment_index) >= MAX_SEGMENTS)
                          || (in_q.segment_type == 3'd0)
                          || (32'(in_q.segment_type) > TYPE_COUNT);
      CMD_MOVE, CMD_MEAN: bad = (32'(in_q.group) > GROUP_COUNT);
      CMD_SCRAM: bad = 1'b0;
      CMD_COVER: bad = (32'(in_q.rod_index) >= ROD_COUNT)
                       || (in_q.layer_height == '0);
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    out_d    = out_q;
    work_d   = work_q;
    ovalid_d = ovalid_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    seg_d    = seg_q;
    nseg_d   = nseg_q;
    pt2_d    = pt2_q;
    cov_d    = cov_q;
    frac_d   = frac_q;
    t_d      = t_q;
    mean_d   = mean_q;
    wr_rod   = 1'b0;
    wr_seg   = 1'b0;
    wr_bot   = 1'b0;
    wr_rod_idx = in_q.rod_index[RodW-1:0];
    wr_ent   = {in_q.rod_index[RodW-1:0], in_q.segment_index[SegW-1:0]};
    wr_bot_val = in_q.position;
    div_start = 1'b0;
    div_num  = '0;
    div_den  = {7'b0, in_q.layer_height, 1'b0};
    lo = '0;
    hi = '0;
    fcl = '0;
    fsum_w = '0;
    if (res.ready && ovalid_q) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd.valid && cmd.ready) state_d = S_SWEEP;
        idx_d  = '0;
        sum_d  = '0;
        cnt_d  = '0;
        seg_d  = '0;
        t_d    = TypW'(1);
        mean_d = 1'b0;
        for (int i = 0; i <= TYPE_COUNT; i++) cov_d[i] = '0;
      end
      S_SWEEP: begin
        work_d = '{fraction: '0, type_index: '0, group_mean: '0,
                   status: ST_OK, last: 1'b1};
        if (bad) begin
          work_d.status = ST_RANGE;
          state_d = S_OUT;
        end else begin
          unique case (in_q.command)
            CMD_LOAD_ROD: begin
              wr_rod = 1'b1;
              state_d = S_OUT;
            end
            CMD_LOAD_SEG: begin
              wr_seg = 1'b1;
              state_d = S_OUT;
            end
            CMD_MOVE, CMD_SCRAM: begin
              wr_rod_idx = idx_q;
              wr_bot = (in_q.command == CMD_SCRAM) || (rd_grp == in_q.group);
              idx_d = idx_q + 1'b1;
              if (32'(idx_q) == ROD_COUNT - 1) state_d = S_OUT;
            end
            CMD_MEAN: begin
              if (rd_grp == in_q.group) begin
                sum_d = sum_q + SumW'(rd_bot);
                cnt_d = cnt_q + 1'b1;
              end
              idx_d = idx_q + 1'b1;
              if (32'(idx_q) == ROD_COUNT - 1) begin
                mean_d = 1'b1;
                state_d = S_DIV_START;
              end
            end
            default: begin
              idx_d  = in_q.rod_index[RodW-1:0];
              state_d = S_SEG_RD;
              seg_d = '0;
            end
          endcase
        end
      end
      S_SEG_RD: begin
        if (seg_q == '0) begin
          nseg_d = rd_nseg;
          pt2_d  = {2'b0, rd_bot, 1'b0};
          if (rd_nseg == '0) state_d = S_DIV_START;
          else state_d = S_SEG_ACC;
        end else begin
          state_d = S_SEG_ACC;
        end
      end
      S_SEG_ACC: begin
        lo = {1'b0, pt2_q};
        hi = {1'b0, pt2_q} + {3'b0, sl_q, 1'b0};
        pt2_d = pt2_q + {2'b0, sl_q, 1'b0};
        if (lo < bot2) lo = bot2;
        if (hi > top2) hi = top2;
        if (st_q != '0 && 32'(st_q) <= TYPE_COUNT && hi > lo)
          cov_d[st_q] = cov_q[st_q] + LenW'(hi - lo);
        seg_d = seg_q + 1'b1;
        if (seg_q + 1'b1 >= nseg_q) state_d = S_DIV_START;
        else state_d = S_SEG_RD;
      end
      S_DIV_START: begin
        if (mean_q) begin
          if (cnt_q == '0) begin
            work_d.status = ST_EMPTY;
            state_d = S_OUT;
          end else begin
            div_start = 1'b1;
            div_num = NumW'(sum_q);
            div_den = DenW'(cnt_q);
            state_d = S_DIV;
          end
        end else begin
          div_start = 1'b1;
          div_num = {cov_q[t_q], 16'b0};
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (mean_q) begin
            work_d.group_mean = div_quo[PosW-1:0];
            state_d = S_OUT;
          end else begin
            fcl = (div_quo > NumW'(OneQ16)) ? OneQ16 : div_quo[FracW-1:0];
            frac_d[t_q] = fcl;
            if (32'(t_q) == TYPE_COUNT) begin
              t_d = '0;
              state_d = S_EMIT;
            end else begin
              t_d = t_q + 1'b1;
              state_d = S_DIV_START;
            end
          end
        end
      end
      S_EMIT: begin
        if (!ovalid_q || res.ready) begin
          ovalid_d = 1'b1;
          out_d.group_mean = '0;
          out_d.status = ST_OK;
          out_d.type_index = 3'(t_q);
          out_d.last = (32'(t_q) == TYPE_COUNT);
          if (t_q == '0) begin
            fsum_w = '0;
            for (int i = 1; i <= TYPE_COUNT; i++)
              fsum_w = fsum_w + (2*FracW+1)'(frac_q[i]);
            out_d.fraction = (fsum_w >= (2*FracW+1)'(OneQ16)) ? '0
                             : FracW'((2*FracW+1)'(OneQ16) - fsum_w);
          end else begin
            out_d.fraction = frac_q[t_q];
          end
          if (32'(t_q) == TYPE_COUNT) state_d = S_IDLE;
          else t_d = t_q + 1'b1;
        end
      end
      S_OUT: begin
        if (!ovalid_q || res.ready) begin
          ovalid_d = 1'b1;
          out_d = work_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      rvalid_q <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (wr_rod) rvalid_q[wr_rod_idx] <= 1'b1;
      if (wr_bot && !rvalid_q[wr_rod_idx]) rvalid_q[wr_rod_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.valid && cmd.ready) in_q <= cmd.data;
    out_q  <= out_d;
    work_q <= work_d;
    idx_q  <= idx_d;
    sum_q  <= sum_d;
    cnt_q  <= cnt_d;
    seg_q  <= seg_d;
    nseg_q <= nseg_d;
    pt2_q  <= pt2_d;
    cov_q  <= cov_d;
    frac_q <= frac_d;
    t_q    <= t_d;
    mean_q <= mean_d;
    sl_q   <= len_mem[rd_ent];
    st_q   <= typ_mem[rd_ent];
    grp_rd_q  <= grp_mem[idx_d];
    bot_rd_q  <= bot_mem[idx_d];
    nseg_rd_q <= nseg_mem[idx_d];
    if (wr_rod) begin
      grp_mem[wr_rod_idx]  <= in_q.group;
      bot_mem[wr_rod_idx]  <= in_q.position;
      nseg_mem[wr_rod_idx] <= in_q.segment_count[SegCW-1:0];
    end
    if (wr_bot) begin
      bot_mem[wr_rod_idx] <= wr_bot_val;
      if (!rvalid_q[wr_rod_idx]) begin
        grp_mem[wr_rod_idx]  <= 5'd0;
        nseg_mem[wr_rod_idx] <= '0;
      end
    end
    if (wr_seg) begin
      len_mem[wr_ent] <= in_q.segment_length;
      typ_mem[wr_ent] <= in_q.segment_type[TypW-1:0];
    end
  end

  crtlc_divider #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );
endmodule
`default_nettype wire
